// File: hdl/jep_pkg.sv
// Shared types and constants for the JSON event parser.
// Used by the front, queue, back and top-level modules; depends on nothing.

package jep_pkg;

  localparam int QDEPTH = 4;

  localparam logic [3:0] EV_OBJB = 4'd0;
  localparam logic [3:0] EV_OBJE = 4'd1;
  localparam logic [3:0] EV_ARRB = 4'd2;
  localparam logic [3:0] EV_ARRE = 4'd3;
  localparam logic [3:0] EV_TRUE = 4'd4;
  localparam logic [3:0] EV_FALSE = 4'd5;
  localparam logic [3:0] EV_NULL = 4'd6;
  localparam logic [3:0] EV_STRB = 4'd7;
  localparam logic [3:0] EV_STRE = 4'd8;
  localparam logic [3:0] EV_NUMC = 4'd9;
  localparam logic [3:0] EV_NUME = 4'd10;
  localparam logic [3:0] EV_ERR = 4'd11;
  localparam logic [3:0] EV_OK = 4'd12;

  localparam logic [4:0] ERR_TOP = 5'd0;
  localparam logic [4:0] ERR_TRAIL = 5'd1;
  localparam logic [4:0] ERR_VALUE = 5'd2;
  localparam logic [4:0] ERR_LITERAL = 5'd3;
  localparam logic [4:0] ERR_INT = 5'd4;
  localparam logic [4:0] ERR_FRAC = 5'd5;
  localparam logic [4:0] ERR_EXP = 5'd6;
  localparam logic [4:0] ERR_KEY = 5'd7;
  localparam logic [4:0] ERR_COLON = 5'd8;
  localparam logic [4:0] ERR_OBJ_SEP = 5'd9;
  localparam logic [4:0] ERR_ARR_SEP = 5'd10;
  localparam logic [4:0] ERR_CTRL = 5'd11;
  localparam logic [4:0] ERR_ESC = 5'd12;
  localparam logic [4:0] ERR_HEX = 5'd13;
  localparam logic [4:0] ERR_SUR_MISSING = 5'd14;
  localparam logic [4:0] ERR_SUR_RANGE = 5'd15;
  localparam logic [4:0] ERR_EOF_STR = 5'd16;
  localparam logic [4:0] ERR_EOF_NEST = 5'd17;
  localparam logic [4:0] ERR_DEPTH = 5'd18;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [3:0] event_kind;
    logic [7:0] event_byte;
    logic [4:0] error_code;
    logic       last_of_run;
  } out_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] data;
    logic [4:0] code;
  } ev_t;

  typedef struct packed {
    logic [2:0]     cnt;
    ev_t  [3:0]     ev;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// File: hdl/jep_front.sv
// Front end of the JSON event parser: parse state machine, nesting stack memory
// and event bundling. Depends on jep_pkg.

module jep_front #(
  parameter int MAX_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  jep_pkg::in_t     item,
  output logic             push,
  output jep_pkg::bundle_t bundle
);
  import jep_pkg::*;

  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  localparam logic [4:0] M_DOC_START = 5'd0;
  localparam logic [4:0] M_DOC_END = 5'd1;
  localparam logic [4:0] M_HALT = 5'd2;
  localparam logic [4:0] M_OBJ_FIRST = 5'd3;
  localparam logic [4:0] M_OBJ_KEY = 5'd4;
  localparam logic [4:0] M_OBJ_COLON = 5'd5;
  localparam logic [4:0] M_OBJ_AFTER = 5'd6;
  localparam logic [4:0] M_ARR_FIRST = 5'd7;
  localparam logic [4:0] M_ARR_AFTER = 5'd8;
  localparam logic [4:0] M_VALUE = 5'd9;
  localparam logic [4:0] M_STR = 5'd10;
  localparam logic [4:0] M_STR_ESC = 5'd11;
  localparam logic [4:0] M_HEX1 = 5'd12;
  localparam logic [4:0] M_SUR_BS = 5'd13;
  localparam logic [4:0] M_SUR_U = 5'd14;
  localparam logic [4:0] M_HEX2 = 5'd15;
  localparam logic [4:0] M_LIT = 5'd16;
  localparam logic [4:0] M_NUM_SIGN = 5'd17;
  localparam logic [4:0] M_NUM_ZERO = 5'd18;
  localparam logic [4:0] M_NUM_INT = 5'd19;
  localparam logic [4:0] M_NUM_DOT = 5'd20;
  localparam logic [4:0] M_NUM_FRAC = 5'd21;
  localparam logic [4:0] M_NUM_E = 5'd22;
  localparam logic [4:0] M_NUM_ESIGN = 5'd23;
  localparam logic [4:0] M_NUM_EXP = 5'd24;

  typedef struct packed {
    logic [2:0]       n;
    logic [3:0][7:0]  b;
  } utf_t;

  function automatic ev_t mk_ev(input logic [3:0] k, input logic [7:0] d,
                                input logic [4:0] c);
    ev_t e;
    e.kind = k;
    e.data = d;
    e.code = c;
    return e;
  endfunction

  function automatic logic [3:0] word_len(input logic [1:0] c);
    logic [3:0] r;
    unique case (c)
      2'd1: r = 4'd4;
      2'd2: r = 4'd5;
      2'd3: r = 4'd4;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] word_char(input logic [1:0] c, input logic [2:0] p);
    logic [39:0] w;
    unique case (c)
      2'd1: w = {8'h00, 8'h65, 8'h75, 8'h72, 8'h74};
      2'd2: w = {8'h65, 8'h73, 8'h6c, 8'h61, 8'h66};
      2'd3: w = {8'h00, 8'h6c, 8'h6c, 8'h75, 8'h6e};
      default: w = '0;
    endcase
    return (p < 3'd5) ? w[8*p +: 8] : 8'h00;
  endfunction

  function automatic logic [3:0] word_event(input logic [1:0] c);
    logic [3:0] r;
    unique case (c)
      2'd1: r = EV_TRUE;
      2'd2: r = EV_FALSE;
      default: r = EV_NULL;
    endcase
    return r;
  endfunction

  function automatic utf_t utf8(input logic [20:0] cp);
    utf_t u;
    u = '0;
    if (cp <= 21'h7F) begin
      u.n = 3'd1;
      u.b[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      u.n = 3'd2;
      u.b[0] = {3'b110, cp[10:6]};
      u.b[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      u.n = 3'd3;
      u.b[0] = {4'b1110, cp[15:12]};
      u.b[1] = {2'b10, cp[11:6]};
      u.b[2] = {2'b10, cp[5:0]};
    end else begin
      u.n = 3'd4;
      u.b[0] = {5'b11110, cp[20:18]};
      u.b[1] = {2'b10, cp[17:12]};
      u.b[2] = {2'b10, cp[11:6]};
      u.b[3] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

  logic [4:0]    mode, mode_next;
  logic [DW-1:0] depth, depth_next;
  logic          top, top_next;
  logic          rd;
  logic [15:0]   acc, acc_next;
  logic [2:0]    left, left_next;
  logic [9:0]    hs, hs_next;
  logic [1:0]    cand, cand_next;
  logic [3:0]    pos, pos_next;
  logic          is_key, key_next;
  logic          stk [MAX_DEPTH];
  logic          push_stk, push_val;
  logic [DW-1:0] rd_full;

  logic [7:0]    b;
  logic          eof, ws, dig, expo, dot, go;
  logic [4:0]    m, vd_mode, close_mode;
  logic [DW-1:0] close_depth;
  logic [3:0]    hexv;
  logic          hexok;
  logic [15:0]   acc_new;
  logic [2:0]    left_dec;
  logic          sv, op_open, op_close, op_obj, op_utf, err;
  logic [4:0]    err_code;
  logic [20:0]   cp;
  utf_t          u;
  logic [2:0]    cnt;
  ev_t [3:0]     evs;

  always_comb begin
    b = item.in_byte;
    eof = item.end_of_input;
    ws = !eof && (b == 8'h20 || b == 8'h09 || b == 8'h0A || b == 8'h0D);
    dig = !eof && b >= 8'h30 && b <= 8'h39;
    expo = !eof && (b == 8'h65 || b == 8'h45);
    dot = !eof && b == 8'h2E;
    hexok = 1'b1;
    hexv = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      hexv = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      hexv = 4'(b[2:0] + 3'd1) + 4'd8;
    end else begin
      hexok = 1'b0;
    end
    acc_new = {acc[11:0], hexv};
    left_dec = (left != 3'd0) ? left - 3'd1 : 3'd0;
    vd_mode = (depth == '0) ? M_DOC_END : (top ? M_OBJ_AFTER : M_ARR_AFTER);
    close_depth = (depth != '0) ? depth - DW'(1) : '0;
    close_mode = (close_depth == '0) ? M_DOC_END : (rd ? M_OBJ_AFTER : M_ARR_AFTER);

    mode_next = mode;
    depth_next = depth;
    top_next = top;
    acc_next = acc;
    left_next = left;
    hs_next = hs;
    cand_next = cand;
    pos_next = pos;
    key_next = is_key;
    push_stk = 1'b0;
    push_val = 1'b0;
    cnt = 3'd0;
    evs = '0;
    go = 1'b0;
    m = mode;
    sv = 1'b0;
    op_open = 1'b0;
    op_close = 1'b0;
    op_obj = 1'b0;
    op_utf = 1'b0;
    err = 1'b0;
    err_code = ERR_TOP;
    cp = '0;
    u = '0;

    if (take && mode != M_HALT) begin
      go = 1'b1;
      if (mode >= M_LIT) begin
        go = 1'b0;
        if (mode == M_LIT) begin
          if (!eof && b >= 8'h61 && b <= 8'h7A) begin
            if (cand == 2'd0 || pos >= word_len(cand) || b != word_char(cand, pos[2:0])) begin
              cand_next = 2'd0;
            end
            if (pos < 4'd15) begin
              pos_next = pos + 4'd1;
            end
          end else if (cand == 2'd0 || pos != word_len(cand)) begin
            err = 1'b1;
            err_code = ERR_LITERAL;
          end else begin
            evs[cnt[1:0]] = mk_ev(word_event(cand), 8'h00, 5'd0);
            cnt = cnt + 3'd1;
            m = vd_mode;
            go = 1'b1;
          end
        end else if (mode == M_NUM_SIGN || mode == M_NUM_DOT || mode == M_NUM_ESIGN ||
                     (mode == M_NUM_E && (eof || (b != 8'h2B && b != 8'h2D)))) begin
          if (!dig) begin
            err = 1'b1;
            err_code = (mode == M_NUM_SIGN) ? ERR_INT :
                       ((mode == M_NUM_DOT) ? ERR_FRAC : ERR_EXP);
          end else begin
            evs[cnt[1:0]] = mk_ev(EV_NUMC, b, 5'd0);
            cnt = cnt + 3'd1;
            if (mode == M_NUM_SIGN) begin
              mode_next = (b == 8'h30) ? M_NUM_ZERO : M_NUM_INT;
            end else begin
              mode_next = (mode == M_NUM_DOT) ? M_NUM_FRAC : M_NUM_EXP;
            end
          end
        end else if (mode == M_NUM_E) begin
          evs[cnt[1:0]] = mk_ev(EV_NUMC, b, 5'd0);
          cnt = cnt + 3'd1;
          mode_next = M_NUM_ESIGN;
        end else if (dig && mode != M_NUM_ZERO) begin
          evs[cnt[1:0]] = mk_ev(EV_NUMC, b, 5'd0);
          cnt = cnt + 3'd1;
        end else if (dot && (mode == M_NUM_ZERO || mode == M_NUM_INT)) begin
          evs[cnt[1:0]] = mk_ev(EV_NUMC, b, 5'd0);
          cnt = cnt + 3'd1;
          mode_next = M_NUM_DOT;
        end else if (expo && mode != M_NUM_EXP) begin
          evs[cnt[1:0]] = mk_ev(EV_NUMC, b, 5'd0);
          cnt = cnt + 3'd1;
          mode_next = M_NUM_E;
        end else begin
          evs[cnt[1:0]] = mk_ev(EV_NUME, 8'h00, 5'd0);
          cnt = cnt + 3'd1;
          m = vd_mode;
          go = 1'b1;
        end
      end

      if (go) begin
        mode_next = m;
        if (m >= M_STR && m <= M_HEX2 && eof) begin
          err = 1'b1;
          err_code = ERR_EOF_STR;
        end else if (m >= M_OBJ_FIRST && m <= M_VALUE && ws) begin
          mode_next = m;
        end else if (m >= M_OBJ_FIRST && m <= M_VALUE && eof) begin
          err = 1'b1;
          err_code = ERR_EOF_NEST;
        end else begin
          unique case (m)
            M_DOC_START: begin
              if (!ws) begin
                if (!eof && (b == 8'h7B || b == 8'h5B)) begin
                  op_open = 1'b1;
                  op_obj = (b == 8'h7B);
                end else begin
                  err = 1'b1;
                  err_code = ERR_TOP;
                end
              end
            end
            M_DOC_END: begin
              if (!ws) begin
                if (eof) begin
                  evs[cnt[1:0]] = mk_ev(EV_OK, 8'h00, 5'd0);
                  cnt = cnt + 3'd1;
                  mode_next = M_HALT;
                end else begin
                  err = 1'b1;
                  err_code = ERR_TRAIL;
                end
              end
            end
            M_OBJ_FIRST, M_OBJ_KEY: begin
              if (m == M_OBJ_FIRST && b == 8'h7D) begin
                op_close = 1'b1;
                op_obj = 1'b1;
              end else if (b == 8'h22) begin
                key_next = 1'b1;
                mode_next = M_STR;
              end else begin
                err = 1'b1;
                err_code = ERR_KEY;
              end
            end
            M_OBJ_COLON: begin
              if (b == 8'h3A) begin
                mode_next = M_VALUE;
              end else begin
                err = 1'b1;
                err_code = ERR_COLON;
              end
            end
            M_OBJ_AFTER: begin
              if (b == 8'h2C) begin
                mode_next = M_OBJ_KEY;
              end else if (b == 8'h7D) begin
                op_close = 1'b1;
                op_obj = 1'b1;
              end else begin
                err = 1'b1;
                err_code = ERR_OBJ_SEP;
              end
            end
            M_ARR_FIRST: begin
              if (b == 8'h5D) begin
                op_close = 1'b1;
              end else begin
                sv = 1'b1;
              end
            end
            M_ARR_AFTER: begin
              if (b == 8'h2C) begin
                mode_next = M_VALUE;
              end else if (b == 8'h5D) begin
                op_close = 1'b1;
              end else begin
                err = 1'b1;
                err_code = ERR_ARR_SEP;
              end
            end
            M_VALUE: begin
              sv = 1'b1;
            end
            M_STR: begin
              if (b == 8'h22) begin
                evs[cnt[1:0]] = mk_ev(EV_STRE, 8'h00, 5'd0);
                cnt = cnt + 3'd1;
                mode_next = is_key ? M_OBJ_COLON : vd_mode;
              end else if (b == 8'h5C) begin
                mode_next = M_STR_ESC;
              end else if (b < 8'h20) begin
                err = 1'b1;
                err_code = ERR_CTRL;
              end else begin
                evs[cnt[1:0]] = mk_ev(EV_STRB, b, 5'd0);
                cnt = cnt + 3'd1;
              end
            end
            M_STR_ESC: begin
              mode_next = M_STR;
              priority case (b)
                8'h22, 8'h5C, 8'h2F: cp = {13'd0, b};
                8'h6E: cp = 21'h0A;
                8'h72: cp = 21'h0D;
                8'h74: cp = 21'h09;
                8'h62: cp = 21'h08;
                8'h66: cp = 21'h0C;
                8'h75: begin
                  acc_next = '0;
                  left_next = 3'd4;
                  mode_next = M_HEX1;
                end
                default: begin
                  err = 1'b1;
                  err_code = ERR_ESC;
                end
              endcase
              op_utf = (b != 8'h75) && !err;
            end
            M_HEX1, M_HEX2: begin
              if (!hexok) begin
                err = 1'b1;
                err_code = ERR_HEX;
              end else begin
                acc_next = acc_new;
                left_next = left_dec;
                if (left_dec == 3'd0) begin
                  if (m == M_HEX1) begin
                    if (acc_new >= 16'hD800 && acc_new <= 16'hDBFF) begin
                      hs_next = acc_new[9:0];
                      mode_next = M_SUR_BS;
                    end else begin
                      cp = {5'd0, acc_new};
                      op_utf = 1'b1;
                      mode_next = M_STR;
                    end
                  end else if (acc_new < 16'hDC00 || acc_new > 16'hDFFF) begin
                    err = 1'b1;
                    err_code = ERR_SUR_RANGE;
                  end else begin
                    cp = {1'b0, hs, acc_new[9:0]} + 21'h10000;
                    op_utf = 1'b1;
                    mode_next = M_STR;
                  end
                end
              end
            end
            M_SUR_BS: begin
              if (b == 8'h5C) begin
                mode_next = M_SUR_U;
              end else begin
                err = 1'b1;
                err_code = ERR_SUR_MISSING;
              end
            end
            M_SUR_U: begin
              if (b == 8'h75) begin
                acc_next = '0;
                left_next = 3'd4;
                mode_next = M_HEX2;
              end else begin
                err = 1'b1;
                err_code = ERR_SUR_MISSING;
              end
            end
            default: begin
              mode_next = m;
            end
          endcase
        end
      end

      if (sv) begin
        if (b == 8'h22) begin
          key_next = 1'b0;
          mode_next = M_STR;
        end else if (b == 8'h7B || b == 8'h5B) begin
          op_open = 1'b1;
          op_obj = (b == 8'h7B);
        end else if (b == 8'h2D || dig) begin
          evs[cnt[1:0]] = mk_ev(EV_NUMC, b, 5'd0);
          cnt = cnt + 3'd1;
          mode_next = (b == 8'h2D) ? M_NUM_SIGN : ((b == 8'h30) ? M_NUM_ZERO : M_NUM_INT);
        end else if (b == 8'h74 || b == 8'h66 || b == 8'h6E) begin
          cand_next = (b == 8'h74) ? 2'd1 : ((b == 8'h66) ? 2'd2 : 2'd3);
          pos_next = 4'd1;
          mode_next = M_LIT;
        end else begin
          err = 1'b1;
          err_code = ERR_VALUE;
        end
      end

      if (op_open) begin
        if (depth >= DW'(MAX_DEPTH)) begin
          err = 1'b1;
          err_code = ERR_DEPTH;
        end else begin
          push_stk = 1'b1;
          push_val = op_obj;
          top_next = op_obj;
          depth_next = depth + DW'(1);
          evs[cnt[1:0]] = mk_ev(op_obj ? EV_OBJB : EV_ARRB, 8'h00, 5'd0);
          cnt = cnt + 3'd1;
          mode_next = op_obj ? M_OBJ_FIRST : M_ARR_FIRST;
        end
      end

      if (op_close) begin
        depth_next = close_depth;
        top_next = rd;
        evs[cnt[1:0]] = mk_ev(op_obj ? EV_OBJE : EV_ARRE, 8'h00, 5'd0);
        cnt = cnt + 3'd1;
        mode_next = close_mode;
      end

      if (op_utf) begin
        u = utf8(cp);
        for (int i = 0; i < 4; i++) begin
          if (3'(i) < u.n) begin
            evs[i] = mk_ev(EV_STRB, u.b[i], 5'd0);
          end
        end
        cnt = u.n;
      end

      if (err) begin
        evs[cnt[1:0]] = mk_ev(EV_ERR, 8'h00, err_code);
        cnt = cnt + 3'd1;
        mode_next = M_HALT;
      end
    end

    rd_full = depth_next - DW'(2);
  end

  assign push = cnt != 3'd0;
  assign bundle.cnt = cnt;
  assign bundle.ev = evs;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_DOC_START;
      depth <= '0;
      top <= 1'b0;
      acc <= '0;
      left <= '0;
      hs <= '0;
      cand <= '0;
      pos <= '0;
      is_key <= 1'b0;
    end else begin
      mode <= mode_next;
      depth <= depth_next;
      top <= top_next;
      acc <= acc_next;
      left <= left_next;
      hs <= hs_next;
      cand <= cand_next;
      pos <= pos_next;
      is_key <= key_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_stk) begin
      stk[depth[AW-1:0]] <= push_val;
    end
    rd <= stk[rd_full[AW-1:0]];
  end

endmodule

// File: hdl/jep_queue.sv
// Short queue of event bundles between the parser front end and the back end.
// Depends on jep_pkg.

module jep_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  jep_pkg::bundle_t wdata,
  input  logic             pop,
  output jep_pkg::bundle_t head,
  output jep_pkg::qstat_t  stat
);
  import jep_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  bundle_t       mem [QDEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [PW:0]   count;

  assign head = mem[rptr];
  assign stat.full = count == (PW + 1)'(QDEPTH);
  assign stat.empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PW'(1);
      end
      if (pop) begin
        rptr <= rptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW + 1)'(1);
      end
    end
  end

endmodule

// File: hdl/jep_back.sv
// Back end of the JSON event parser: unpacks queued bundles into single events
// held in the output register. Depends on jep_pkg.

module jep_back (
  input  logic             clk,
  input  logic             rst,
  input  jep_pkg::bundle_t head,
  input  jep_pkg::qstat_t  stat,
  output logic             pop,
  output logic             dst_valid,
  input  logic             dst_stall,
  output jep_pkg::out_t    dst_data
);
  import jep_pkg::*;

  logic [1:0] idx;
  logic       load, last;
  ev_t        cur;

  assign load = !stat.empty && (!dst_valid || !dst_stall);
  assign last = {1'b0, idx} == (head.cnt - 3'd1);
  assign cur = head.ev[idx];
  assign pop = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
      idx <= '0;
    end else begin
      if (load) begin
        dst_valid <= 1'b1;
        idx <= last ? 2'd0 : idx + 2'd1;
      end else if (!dst_stall) begin
        dst_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dst_data.event_kind <= cur.kind;
      dst_data.event_byte <= cur.data;
      dst_data.error_code <= cur.code;
      dst_data.last_of_run <= last;
    end
  end

endmodule

// File: hdl/json_event_parser_unit.sv
// Top level of the JSON event parser: front end, bundle queue and back end.
// Depends on jep_pkg, jep_front, jep_queue and jep_back.

// The parser takes one document byte (or the end-of-input marker) per cycle
// and turns it into zero to four events, which it hands out one per cycle on
// the result channel while dst_stall is low, each carrying last_of_run on the
// final event of its byte. The front end decides all events of a byte in the
// cycle the byte transfers and parks them as one bundle in a four-entry queue;
// the back end drains that queue at one event per cycle unless dst_stall holds
// it, and the input stalls only while the queue is full. The nesting stack is
// an internal memory of MAX_DEPTH one-bit entries with a registered read of the
// entry below the top; it needs no clearing after reset. After an error or the
// final docok event the block consumes further input without producing results
// until it is reset.

module json_event_parser_unit #(
  parameter int MAX_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          src_valid,
  output logic          src_stall,
  input  jep_pkg::in_t  src_data,
  output logic          dst_valid,
  input  logic          dst_stall,
  output jep_pkg::out_t dst_data
);
  import jep_pkg::*;

  logic    take, push, pop;
  bundle_t bundle, head;
  qstat_t  stat;

  assign src_stall = stat.full;
  assign take = src_valid && !stat.full;

  jep_front #(
    .MAX_DEPTH(MAX_DEPTH)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .item  (src_data),
    .push  (push),
    .bundle(bundle)
  );

  jep_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .wdata(bundle),
    .pop  (pop),
    .head (head),
    .stat (stat)
  );

  jep_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .stat     (stat),
    .pop      (pop),
    .dst_valid(dst_valid),
    .dst_stall(dst_stall),
    .dst_data (dst_data)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && stat.full))
    else $error("bundle written into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && stat.empty))
    else $error("bundle removed from an empty queue");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_data.event_kind == EV_ERR |-> dst_data.last_of_run)
    else $error("error event is not the final event of its byte");

  a_code_only_on_error: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_data.event_kind != EV_ERR |-> dst_data.error_code == 5'd0)
    else $error("nonzero error code on a non-error event");

endmodule
